[rtl/core/sba_pkg.sv]
`default_nettype none
package sba_pkg;

  localparam int GRANULE_BYTES   = 16;
  localparam int GRAN_SHIFT      = 4;
  localparam int SIZE_CLASSES    = 12;
  localparam int HEADER_BYTES    = 112;
  localparam int LOWEST_FREEABLE = 8192;
  localparam int POOL_MAX_BYTES  = 262144;
  localparam int SEG_BYTES       = 65536;
  localparam int LARGEST_CLASS   = GRANULE_BYTES << (SIZE_CLASSES - 1);
  localparam int TABLE_DEPTH     = POOL_MAX_BYTES / GRANULE_BYTES;
  localparam int TAB_AW          = $clog2(TABLE_DEPTH);
  localparam int OFF_W           = 20;
  localparam int MASK19          = 524287;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_UNCONF     = 4'd1,
    ST_ZERO       = 4'd2,
    ST_TOO_LARGE  = 4'd3,
    ST_NO_SPACE   = 4'd4,
    ST_MISALIGNED = 4'd5,
    ST_BAD_ADDR   = 4'd6,
    ST_CROSS64K   = 4'd7,
    ST_OUTSIDE    = 4'd8,
    ST_DOUBLE     = 4'd9
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_BASE = 2'd0,
    CFG_INIT = 2'd1,
    CFG_CEIL = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [23:0] base;
    logic [18:0] init;
    logic [24:0] ceil;
  } cfg_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] bytes;
    logic [23:0] addr;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [23:0] addr;
    logic [15:0] gbytes;
    logic [18:0] used;
    logic [18:0] peak;
    logic [18:0] committed;
  } result_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [TAB_AW-1:0] addr;
    logic [4:0]        wdata;
  } tab_req_t;

  function automatic logic [3:0] class_of(logic [OFF_W-1:0] v);
    logic [3:0] k;
    k = 4'(SIZE_CLASSES);
    for (int i = SIZE_CLASSES - 1; i >= 0; i--) begin
      if (v <= (OFF_W'(GRANULE_BYTES) << i)) k = 4'(i);
    end
    return k;
  endfunction

  function automatic logic [OFF_W-1:0] floor_pow2(logic [OFF_W-1:0] v);
    logic [OFF_W-1:0] c;
    c = OFF_W'(GRANULE_BYTES);
    for (int i = 0; i < SIZE_CLASSES; i++) begin
      if (v >= (OFF_W'(GRANULE_BYTES) << i)) c = OFF_W'(GRANULE_BYTES) << i;
    end
    return c;
  endfunction

  function automatic logic is_pow2(logic [OFF_W-1:0] v);
    return (v != '0) && ((v & (v - OFF_W'(1))) == '0);
  endfunction

endpackage
`default_nettype wire

[rtl/core/sba_table.sv]
`default_nettype none
module sba_table (
  input  logic              clk_i,
  input  sba_pkg::tab_req_t req_i,
  output logic [4:0]        rdata_o
);
  import sba_pkg::*;

  logic [4:0] mem_q [TABLE_DEPTH];
  logic [4:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem_q[req_i.addr] <= req_i.wdata;
    if (req_i.re) rdata_q <= mem_q[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/core/sba_engine.sv]
`default_nettype none
module sba_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              init_i,
  input  sba_pkg::cfg_t     cfg_i,
  input  logic              start_i,
  input  sba_pkg::item_t    item_i,
  output logic              idle_o,
  input  logic              res_ready_i,
  output logic              res_valid_o,
  output sba_pkg::result_t  res_o,
  output sba_pkg::tab_req_t tab_req_o,
  input  logic [4:0]        tab_rdata_i
);
  import sba_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_CLR      = 16'h0002,
    S_CHK      = 16'h0004,
    S_ALLOC    = 16'h0008,
    S_FREE     = 16'h0010,
    S_FREE_CHK = 16'h0020,
    S_SCAN     = 16'h0040,
    S_PICK     = 16'h0080,
    S_GROW     = 16'h0100,
    S_RS       = 16'h0200,
    S_RS_ACHK  = 16'h0400,
    S_RS_MRG   = 16'h0800,
    S_RS_MCHK  = 16'h1000,
    S_RS_FILE  = 16'h2000,
    S_RS_SPLIT = 16'h4000,
    S_FIN      = 16'h8000
  } state_e;

  typedef enum logic [1:0] {
    R_INIT  = 2'd0,
    R_GROW  = 2'd1,
    R_ALLOC = 2'd2,
    R_FREE  = 2'd3
  } ret_e;

  // control state
  state_e state_q, state_d;
  ret_e ret_q, ret_d;
  logic [TAB_AW-1:0] clr_q, clr_d;
  logic cfg_ok_q, cfg_ok_d;
  logic [18:0] pool_q, pool_d, used_q, used_d, peak_q, peak_d;
  logic grown_q, grown_d, pend_q, pend_d, get_ok_q, get_ok_d;
  logic [TAB_AW:0] scan_q, scan_d;
  logic [SIZE_CLASSES-1:0] seen_q, seen_d;

  // payload
  item_t item_q, item_d;
  logic [3:0] first_q, first_d;
  logic [15:0] size_q, size_d;
  logic [TAB_AW-1:0] pidx_q, pidx_d;
  logic [SIZE_CLASSES-1:0][TAB_AW-1:0] low_q, low_d;
  logic [OFF_W-1:0] rs_off_q, rs_off_d, rs_size_q, rs_size_d, rs_tgt_q, rs_tgt_d;
  status_e res_status_q, res_status_d;
  logic [23:0] res_addr_q, res_addr_d;
  logic [15:0] res_bytes_q, res_bytes_d;

  // configuration checks
  logic [25:0] bn, bn1, ceil_diff;
  logic cfg_good;
  assign bn        = 26'(cfg_i.base) + 26'(cfg_i.init);
  assign bn1       = bn - 26'd1;
  assign ceil_diff = 26'(cfg_i.ceil) - bn;
  assign cfg_good  = (cfg_i.base >= 24'(LOWEST_FREEABLE)) && (cfg_i.base[3:0] == '0)
                  && (cfg_i.init > 19'(HEADER_BYTES)) && (cfg_i.init[3:0] == '0)
                  && (20'(cfg_i.init) <= 20'(POOL_MAX_BYTES))
                  && ((cfg_i.base[15:0] == '0) || (10'(cfg_i.base[23:16]) == bn1[25:16]))
                  && (26'(cfg_i.ceil) >= bn) && (ceil_diff[15:0] == '0);

  // allocate sizing
  logic [3:0] first_c;
  logic [16:0] cls_bytes, rnd_bytes;
  logic [15:0] carve_c;
  assign first_c   = class_of(OFF_W'(item_q.bytes));
  assign cls_bytes = 17'(GRANULE_BYTES) << first_c;
  assign rnd_bytes = (17'(item_q.bytes) + 17'd255) & ~17'd255;
  assign carve_c   = (18'(cls_bytes) >= 18'(item_q.bytes) + 18'd256) ? rnd_bytes[15:0]
                                                                    : cls_bytes[15:0];

  // free checks
  logic [24:0] fr_end1, fr_lim, fr_top;
  logic [24:0] fr_diff;
  logic [OFF_W-1:0] fr_off;
  logic fr_outside;
  assign fr_end1    = 25'(item_q.addr) + 25'(item_q.bytes) - 25'd1;
  assign fr_top     = 25'(item_q.addr) + 25'(item_q.bytes);
  assign fr_lim     = 25'(cfg_i.base) + 25'(pool_q);
  assign fr_diff    = 25'(item_q.addr) - 25'(cfg_i.base);
  assign fr_off     = fr_diff[OFF_W-1:0];
  assign fr_outside = (item_q.addr < cfg_i.base) || (25'(item_q.addr) >= fr_lim)
                   || (fr_top > fr_lim);

  // class pick over the scan results
  logic found;
  logic [3:0] pick_k;
  logic [OFF_W-1:0] pick_off, pick_len;
  logic [OFF_W-1:0] used_sum;
  always_comb begin
    found  = 1'b0;
    pick_k = '0;
    for (int k = SIZE_CLASSES - 1; k >= 0; k--) begin
      if (seen_q[k] && (4'(k) >= first_q)) begin
        found  = 1'b1;
        pick_k = 4'(k);
      end
    end
  end
  assign pick_off = {low_q[pick_k], 4'b0} & OFF_W'({TAB_AW + GRAN_SHIFT{1'b1}});
  assign pick_len = OFF_W'(GRANULE_BYTES) << pick_k;
  assign used_sum = OFF_W'(used_q) + OFF_W'(size_q);

  // growth limits
  logic grow_bad;
  assign grow_bad = (26'(cfg_i.base) + 26'(pool_q) + 26'(SEG_BYTES) > 26'(cfg_i.ceil))
                 || (20'(pool_q) + 20'(SEG_BYTES) > 20'(POOL_MAX_BYTES));

  // span release helpers
  logic [OFF_W-1:0] e_len, rs_sum, rs_buddy, split_c;
  logic [23:0] res_full;
  logic [4:0] e_get;
  logic rs_done;
  assign e_get    = get_ok_q ? tab_rdata_i : 5'd0;
  assign e_len    = OFF_W'(GRANULE_BYTES) << (e_get - 5'd1);
  assign rs_sum   = rs_off_q + rs_size_q;
  assign rs_buddy = rs_off_q ^ rs_size_q;
  assign split_c  = floor_pow2(rs_size_q);
  assign res_full = cfg_i.base + 24'(pick_off);

  always_comb begin
    state_d = state_q; ret_d = ret_q; clr_d = clr_q; cfg_ok_d = cfg_ok_q;
    pool_d = pool_q; used_d = used_q; peak_d = peak_q; grown_d = grown_q;
    pend_d = pend_q; get_ok_d = get_ok_q; scan_d = scan_q; seen_d = seen_q;
    item_d = item_q; first_d = first_q; size_d = size_q; pidx_d = pidx_q;
    low_d = low_q; rs_off_d = rs_off_q; rs_size_d = rs_size_q; rs_tgt_d = rs_tgt_q;
    res_status_d = res_status_q; res_addr_d = res_addr_q; res_bytes_d = res_bytes_q;
    tab_req_o = '0;
    res_valid_o = 1'b0;
    rs_done = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          item_d       = item_i;
          res_status_d = ST_OK;
          res_addr_d   = '0;
          res_bytes_d  = '0;
          state_d      = (item_i.cmd == CMD_FREE) ? S_FREE : S_ALLOC;
        end
      end
      S_CLR: begin
        tab_req_o.we   = 1'b1;
        tab_req_o.addr = clr_q;
        clr_d          = clr_q + TAB_AW'(1);
        if (clr_q == TAB_AW'(TABLE_DEPTH - 1)) state_d = S_CHK;
      end
      S_CHK: begin
        used_d = '0;
        peak_d = '0;
        if (cfg_good) begin
          cfg_ok_d  = 1'b1;
          pool_d    = cfg_i.init;
          rs_off_d  = OFF_W'(HEADER_BYTES);
          rs_size_d = OFF_W'(cfg_i.init) - OFF_W'(HEADER_BYTES);
          ret_d     = R_INIT;
          state_d   = S_RS;
        end else begin
          cfg_ok_d = 1'b0;
          pool_d   = '0;
          state_d  = S_IDLE;
        end
      end
      S_ALLOC: begin
        if (!cfg_ok_q) begin
          res_status_d = ST_UNCONF;
          state_d = S_FIN;
        end else if (item_q.bytes == '0) begin
          res_status_d = ST_ZERO;
          state_d = S_FIN;
        end else if (first_c >= 4'(SIZE_CLASSES)) begin
          res_status_d = ST_TOO_LARGE;
          state_d = S_FIN;
        end else begin
          first_d = first_c;
          size_d  = carve_c;
          grown_d = 1'b0;
          seen_d  = '0;
          scan_d  = '0;
          pend_d  = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_FREE: begin
        state_d = S_FIN;
        if (!cfg_ok_q) res_status_d = ST_UNCONF;
        else if (item_q.bytes == '0) res_status_d = ST_ZERO;
        else if (item_q.addr[3:0] != '0) res_status_d = ST_MISALIGNED;
        else if ((item_q.addr < 24'(LOWEST_FREEABLE)) || (item_q.addr[15:0] == '0))
          res_status_d = ST_BAD_ADDR;
        else if (9'(item_q.addr[23:16]) != fr_end1[24:16]) res_status_d = ST_CROSS64K;
        else if (fr_outside) res_status_d = ST_OUTSIDE;
        else begin
          tab_req_o.re   = 1'b1;
          tab_req_o.addr = fr_off[TAB_AW+GRAN_SHIFT-1:GRAN_SHIFT];
          get_ok_d       = 1'b1;
          rs_off_d       = fr_off;
          rs_size_d      = OFF_W'(item_q.bytes);
          state_d        = S_FREE_CHK;
        end
      end
      S_FREE_CHK: begin
        if (e_get != '0) begin
          res_status_d = ST_DOUBLE;
          state_d = S_FIN;
        end else begin
          used_d  = (used_q > 19'(item_q.bytes)) ? used_q - 19'(item_q.bytes) : '0;
          ret_d   = R_FREE;
          state_d = S_RS;
        end
      end
      S_SCAN: begin
        // one read per cycle, data lands in the next cycle
        if (scan_q < pool_q[18:GRAN_SHIFT]) begin
          tab_req_o.re   = 1'b1;
          tab_req_o.addr = scan_q[TAB_AW-1:0];
          pend_d = 1'b1;
          pidx_d = scan_q[TAB_AW-1:0];
          scan_d = scan_q + (TAB_AW + 1)'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          for (int k = 0; k < SIZE_CLASSES; k++) begin
            if ((tab_rdata_i == 5'(k + 1)) && !seen_q[k]) begin
              seen_d[k] = 1'b1;
              low_d[k]  = pidx_q;
            end
          end
        end
        if ((scan_q >= pool_q[18:GRAN_SHIFT]) && !pend_q) state_d = S_PICK;
      end
      S_PICK: begin
        if (found) begin
          tab_req_o.we   = 1'b1;
          tab_req_o.addr = low_q[pick_k];
          used_d      = (used_sum > OFF_W'(MASK19)) ? 19'(MASK19) : used_sum[18:0];
          peak_d      = ((used_sum > OFF_W'(MASK19) ? 19'(MASK19) : used_sum[18:0]) > peak_q)
                        ? (used_sum > OFF_W'(MASK19) ? 19'(MASK19) : used_sum[18:0]) : peak_q;
          res_addr_d  = res_full;
          res_bytes_d = size_q;
          if (pick_len > OFF_W'(size_q)) begin
            rs_off_d  = pick_off + OFF_W'(size_q);
            rs_size_d = pick_len - OFF_W'(size_q);
            ret_d     = R_ALLOC;
            state_d   = S_RS;
          end else begin
            state_d = S_FIN;
          end
        end else if (!grown_q) begin
          state_d = S_GROW;
        end else begin
          res_status_d = ST_NO_SPACE;
          state_d = S_FIN;
        end
      end
      S_GROW: begin
        if (grow_bad) begin
          res_status_d = ST_NO_SPACE;
          state_d = S_FIN;
        end else begin
          pool_d    = pool_q + 19'(SEG_BYTES);
          grown_d   = 1'b1;
          rs_off_d  = OFF_W'(pool_q) + OFF_W'(GRANULE_BYTES);
          rs_size_d = OFF_W'(SEG_BYTES - GRANULE_BYTES);
          ret_d     = R_GROW;
          state_d   = S_RS;
        end
      end
      S_RS: begin
        if (!is_pow2(rs_size_q)) begin
          // look at the block just above the span
          get_ok_d = (rs_sum[3:0] == '0) && (rs_sum < OFF_W'(pool_q));
          tab_req_o.re   = 1'b1;
          tab_req_o.addr = rs_sum[TAB_AW+GRAN_SHIFT-1:GRAN_SHIFT];
          rs_tgt_d = rs_sum;
          state_d  = S_RS_ACHK;
        end else if (rs_size_q <= OFF_W'(LARGEST_CLASS)) begin
          state_d = S_RS_MRG;
        end else begin
          state_d = S_RS_SPLIT;
        end
      end
      S_RS_ACHK: begin
        if (e_get == '0) begin
          state_d = S_RS_SPLIT;
        end else begin
          tab_req_o.we   = 1'b1;
          tab_req_o.addr = rs_tgt_q[TAB_AW+GRAN_SHIFT-1:GRAN_SHIFT];
          rs_size_d = rs_size_q + e_len;
          state_d   = S_RS;
        end
      end
      S_RS_MRG: begin
        if ((rs_size_q < OFF_W'(LARGEST_CLASS)) && (rs_buddy != '0)
            && (rs_buddy < OFF_W'(pool_q))) begin
          get_ok_d = (rs_buddy[3:0] == '0);
          tab_req_o.re   = 1'b1;
          tab_req_o.addr = rs_buddy[TAB_AW+GRAN_SHIFT-1:GRAN_SHIFT];
          rs_tgt_d = rs_buddy;
          state_d  = S_RS_MCHK;
        end else begin
          state_d = S_RS_FILE;
        end
      end
      S_RS_MCHK: begin
        if ((e_get == '0) || (e_len != rs_size_q)) begin
          state_d = S_RS_FILE;
        end else begin
          tab_req_o.we   = 1'b1;
          tab_req_o.addr = rs_tgt_q[TAB_AW+GRAN_SHIFT-1:GRAN_SHIFT];
          if (rs_tgt_q < rs_off_q) rs_off_d = rs_tgt_q;
          rs_size_d = rs_size_q << 1;
          state_d   = S_RS_MRG;
        end
      end
      S_RS_FILE: begin
        tab_req_o.we    = (rs_off_q[3:0] == '0) && (rs_off_q[OFF_W-1:TAB_AW+GRAN_SHIFT] == '0);
        tab_req_o.addr  = rs_off_q[TAB_AW+GRAN_SHIFT-1:GRAN_SHIFT];
        tab_req_o.wdata = 5'(class_of(rs_size_q)) + 5'd1;
        rs_done = 1'b1;
      end
      S_RS_SPLIT: begin
        if (rs_size_q >= OFF_W'(GRANULE_BYTES)) begin
          tab_req_o.we    = (rs_off_q[3:0] == '0)
                         && (rs_off_q[OFF_W-1:TAB_AW+GRAN_SHIFT] == '0);
          tab_req_o.addr  = rs_off_q[TAB_AW+GRAN_SHIFT-1:GRAN_SHIFT];
          tab_req_o.wdata = 5'(class_of(split_c)) + 5'd1;
          rs_off_d  = rs_off_q + split_c;
          rs_size_d = rs_size_q - split_c;
        end else begin
          rs_done = 1'b1;
        end
      end
      S_FIN: begin
        if (res_ready_i) begin
          res_valid_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (rs_done) begin
      case (ret_q)
        R_INIT:  state_d = S_IDLE;
        R_GROW: begin
          seen_d  = '0;
          scan_d  = '0;
          pend_d  = 1'b0;
          state_d = S_SCAN;
        end
        default: state_d = S_FIN;
      endcase
    end

    // a configuration write restarts the clearing pass
    if (init_i) begin
      state_d = S_CLR;
      clr_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      ret_q    <= R_INIT;
      clr_q    <= '0;
      cfg_ok_q <= 1'b0;
      pool_q   <= '0;
      used_q   <= '0;
      peak_q   <= '0;
      grown_q  <= 1'b0;
      pend_q   <= 1'b0;
      get_ok_q <= 1'b0;
      scan_q   <= '0;
      seen_q   <= '0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      clr_q    <= clr_d;
      cfg_ok_q <= cfg_ok_d;
      pool_q   <= pool_d;
      used_q   <= used_d;
      peak_q   <= peak_d;
      grown_q  <= grown_d;
      pend_q   <= pend_d;
      get_ok_q <= get_ok_d;
      scan_q   <= scan_d;
      seen_q   <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    first_q      <= first_d;
    size_q       <= size_d;
    pidx_q       <= pidx_d;
    low_q        <= low_d;
    rs_off_q     <= rs_off_d;
    rs_size_q    <= rs_size_d;
    rs_tgt_q     <= rs_tgt_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_bytes_q  <= res_bytes_d;
  end

  assign idle_o = (state_q == S_IDLE);
  assign res_o  = '{status: res_status_q, addr: res_addr_q, gbytes: res_bytes_q,
                    used: used_q, peak: peak_q, committed: pool_q};

  a_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tab_req_o.we && tab_req_o.re))
    else $error("table read and write in one cycle");

  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= used_q)
    else $error("peak below used bytes");

  a_pool_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    20'(pool_q) <= 20'(POOL_MAX_BYTES))
    else $error("pool beyond maximum");

  a_unconf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !cfg_ok_q) |-> (pool_q == '0))
    else $error("unconfigured pool has size");

  a_res_only_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (state_q == S_IDLE || state_q == S_CLR))
    else $error("result without return to idle");

endmodule
`default_nettype wire

[rtl/core/size_class_buddy_allocator.sv]
// size-class buddy allocator
// input channel: in_valid_i / in_stall_o with command_i (0 allocate, 1 free),
//   request_bytes_i and address_i; a transaction moves when valid is high and
//   stall is low. one command is in work at a time.
// output channel: out_valid_o / out_stall_i, one result transaction per command.
//   the result sits in an output register, so while the receiver stalls one
//   more command can be taken and worked on; its result then waits in the
//   sequencer and in_stall_o stays high until the output register drains.
// config port: cfg_valid_i / cfg_ready_o (always ready), cfg_index_i selects
//   pool_base, pool_initial_bytes or pool_ceiling; a write to one of them
//   re-initializes the pool.
// a refused command goes from its check state straight to the result; a
//   double free is caught after one table read; any other free releases its
//   span, absorbing blocks above, merging buddies or splitting into pieces.
//   an allocate scans the free table at one entry per cycle, committed_bytes
//   / 16 entries, and again after growth, through the single table port.
// reset and config writes: the free table is cleared one entry per cycle,
//   then seeded; in_stall_o stays high during that pass.
`default_nettype none
module size_class_buddy_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [15:0] request_bytes_i,
  input  logic [23:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic [23:0] granted_address_o,
  output logic [15:0] granted_bytes_o,
  output logic [18:0] used_bytes_o,
  output logic [18:0] peak_bytes_o,
  output logic [18:0] committed_bytes_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [24:0] cfg_data_i
);
  import sba_pkg::*;

  cfg_t     cfg_q;
  logic     cfg_hit;
  cfg_idx_e cfg_idx;

  logic     eng_idle, res_valid, res_ready;
  result_t  res, out_q;
  logic     out_valid_q;
  item_t    item;
  tab_req_t tab_req;
  logic [4:0] tab_rdata;

  // config registers, always ready
  assign cfg_ready_o = 1'b1;
  assign cfg_idx     = cfg_idx_e'(cfg_index_i);
  assign cfg_hit     = cfg_valid_i && ((cfg_idx == CFG_BASE) || (cfg_idx == CFG_INIT)
                                    || (cfg_idx == CFG_CEIL));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base <= 24'(SEG_BYTES);
      cfg_q.init <= 19'(SEG_BYTES);
      cfg_q.ceil <= 25'(327680);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx)
        CFG_BASE: cfg_q.base <= cfg_data_i[23:0];
        CFG_INIT: cfg_q.init <= cfg_data_i[18:0];
        CFG_CEIL: cfg_q.ceil <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input side: taken only when the sequencer is idle
  assign in_stall_o = !eng_idle;
  assign item = '{cmd: cmd_e'(command_i), bytes: request_bytes_i, addr: address_i};

  sba_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_i      (cfg_hit),
    .cfg_i       (cfg_q),
    .start_i     (in_valid_i && eng_idle),
    .item_i      (item),
    .idle_o      (eng_idle),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .tab_req_o   (tab_req),
    .tab_rdata_i (tab_rdata)
  );

  sba_table u_table (
    .clk_i   (clk_i),
    .req_i   (tab_req),
    .rdata_o (tab_rdata)
  );

  // output register: free when empty or being taken this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) out_q <= res;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign granted_address_o = out_q.addr;
  assign granted_bytes_o   = out_q.gbytes;
  assign used_bytes_o      = out_q.used;
  assign peak_bytes_o      = out_q.peak;
  assign committed_bytes_o = out_q.committed;

endmodule
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import sba_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int LONG_HOLD      = 3000;
  localparam int MAX_REPORTS    = 10;

  // one row of the directed table; typed_chk marks rows whose status is obvious
  typedef struct {
    cmd_e        cmd;
    int unsigned nbytes;
    int unsigned addr;
    int          grant_row;  // >= 0: free the block granted to that row
    bit          typed_chk;
    status_e     typed;
  } row_t;

  typedef struct {
    result_t r;
    bit      typed_chk;
    status_e typed;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        command_i = 1'b0;
  logic [15:0] request_bytes_i = '0;
  logic [23:0] address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  status_o;
  logic [23:0] granted_address_o;
  logic [15:0] granted_bytes_o;
  logic [18:0] used_bytes_o;
  logic [18:0] peak_bytes_o;
  logic [18:0] committed_bytes_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [24:0] cfg_data_i = '0;

  always #1 clk_i = ~clk_i;

  size_class_buddy_allocator dut (.*);

  // ---------------------------------------------------------------------------
  // allocator shadow: free-block table, counters and register copies
  // ---------------------------------------------------------------------------
  byte unsigned shadow_tab[TABLE_DEPTH];
  int unsigned  sh_pool, sh_used, sh_peak;
  bit           sh_ok;
  int unsigned  reg_base = 65536, reg_init = 65536, reg_ceil = 327680;

  function automatic bit pow2(int unsigned v);
    return v != 0 && (v & (v - 1)) == 0;
  endfunction

  function automatic int unsigned size_class(int unsigned b);
    int unsigned k, c;
    k = 0;
    c = GRANULE_BYTES;
    while (c < b && k < SIZE_CLASSES) begin
      c <<= 1;
      k++;
    end
    return k;
  endfunction

  function automatic int unsigned tab_rd(int unsigned off);
    if (off % GRANULE_BYTES != 0 || off >= sh_pool) return 0;
    if (off / GRANULE_BYTES >= TABLE_DEPTH) return 0;
    return shadow_tab[off / GRANULE_BYTES];
  endfunction

  function automatic void tab_wr(int unsigned off, int unsigned v);
    if (off % GRANULE_BYTES != 0 || off / GRANULE_BYTES >= TABLE_DEPTH) return;
    shadow_tab[off / GRANULE_BYTES] = v & 31;
  endfunction

  // hand a span back: absorb blocks above, merge buddies, or split into a run
  function automatic void return_span(int unsigned off, int unsigned size);
    int unsigned e, buddy, c;
    while (!pow2(size)) begin
      e = tab_rd(off + size);
      if (e == 0) break;
      tab_wr(off + size, 0);
      size += GRANULE_BYTES << (e - 1);
    end
    if (pow2(size) && size <= LARGEST_CLASS) begin
      while (size < LARGEST_CLASS) begin
        buddy = off ^ size;
        if (buddy == 0 || buddy >= sh_pool) break;
        e = tab_rd(buddy);
        if (e == 0 || (GRANULE_BYTES << (e - 1)) != size) break;
        tab_wr(buddy, 0);
        if (buddy < off) off = buddy;
        size <<= 1;
      end
      tab_wr(off, size_class(size) + 1);
      return;
    end
    while (size >= GRANULE_BYTES) begin
      c = GRANULE_BYTES;
      while ((c << 1) <= size && c < LARGEST_CLASS) c <<= 1;
      tab_wr(off, size_class(c) + 1);
      off += c;
      size -= c;
    end
  endfunction

  function automatic void pool_setup();
    int unsigned b, n;
    b = reg_base;
    n = reg_init;
    foreach (shadow_tab[i]) shadow_tab[i] = 0;
    sh_used = 0;
    sh_peak = 0;
    sh_pool = 0;
    sh_ok = 1'b0;
    if (b < LOWEST_FREEABLE || b % GRANULE_BYTES != 0) return;
    if (n <= HEADER_BYTES || n % GRANULE_BYTES != 0 || n > POOL_MAX_BYTES) return;
    if ((b & 32'hFFFF) != 0 && (b >> 16) != ((b + n - 1) >> 16)) return;
    if (reg_ceil < b + n || ((reg_ceil - (b + n)) & 32'hFFFF) != 0) return;
    sh_ok = 1'b1;
    sh_pool = n;
    return_span(HEADER_BYTES, n - HEADER_BYTES);
  endfunction

  function automatic bit pool_grow();
    int unsigned old;
    old = sh_pool;
    if (reg_base + sh_pool + SEG_BYTES > reg_ceil) return 1'b0;
    if (sh_pool + SEG_BYTES > POOL_MAX_BYTES) return 1'b0;
    sh_pool += SEG_BYTES;
    return_span(old + GRANULE_BYTES, SEG_BYTES - GRANULE_BYTES);
    return 1'b1;
  endfunction

  // lowest block of the first non-empty class at or above first
  function automatic bit carve_block(int unsigned first, int unsigned size,
                                     output int unsigned where);
    int unsigned lowest[SIZE_CLASSES];
    bit          seen[SIZE_CLASSES];
    int unsigned lim, e, len;
    where = 0;
    foreach (seen[k]) begin
      seen[k] = 1'b0;
      lowest[k] = 0;
    end
    lim = sh_pool / GRANULE_BYTES;
    if (lim > TABLE_DEPTH) lim = TABLE_DEPTH;
    for (int unsigned i = 0; i < lim; i++) begin
      e = shadow_tab[i];
      if (e != 0 && e <= SIZE_CLASSES && !seen[e-1]) begin
        seen[e-1] = 1'b1;
        lowest[e-1] = i * GRANULE_BYTES;
      end
    end
    for (int unsigned k = first; k < SIZE_CLASSES; k++) begin
      if (!seen[k]) continue;
      len = GRANULE_BYTES << k;
      tab_wr(lowest[k], 0);
      if (len > size) return_span(lowest[k] + size, len - size);
      sh_used += size;
      if (sh_used > MASK19) sh_used = MASK19;
      if (sh_used > sh_peak) sh_peak = sh_used;
      where = lowest[k];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t predict_reply(item_t it);
    result_t     r;
    status_e     st;
    int unsigned nb, at, first, c, size, off;
    nb = it.bytes;
    at = it.addr;
    r = '0;
    st = ST_OK;
    if (!sh_ok) st = ST_UNCONF;
    else if (it.cmd == CMD_ALLOC) begin
      first = size_class(nb);
      if (nb == 0) st = ST_ZERO;
      else if (first >= SIZE_CLASSES) st = ST_TOO_LARGE;
      else begin
        c = GRANULE_BYTES << first;
        size = (c >= nb + 256) ? ((nb + 255) & ~32'd255) : c;
        if (!carve_block(first, size, off)) begin
          if (!pool_grow() || !carve_block(first, size, off)) st = ST_NO_SPACE;
        end
        if (st == ST_OK) begin
          r.addr = 24'(reg_base + off);
          r.gbytes = 16'(size);
        end
      end
    end else begin
      if (nb == 0) st = ST_ZERO;
      else if (at % GRANULE_BYTES != 0) st = ST_MISALIGNED;
      else if (at < LOWEST_FREEABLE || (at & 32'hFFFF) == 0) st = ST_BAD_ADDR;
      else if ((at >> 16) != ((at + nb - 1) >> 16)) st = ST_CROSS64K;
      else if (at < reg_base || at >= reg_base + sh_pool ||
               at + nb > reg_base + sh_pool) st = ST_OUTSIDE;
      else if (tab_rd(at - reg_base) != 0) st = ST_DOUBLE;
      else begin
        sh_used = (sh_used > nb) ? sh_used - nb : 0;
        return_span(at - reg_base, nb);
      end
    end
    r.status = st;
    r.used = 19'(sh_used);
    r.peak = 19'(sh_peak);
    r.committed = 19'(sh_pool);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // bookkeeping
  // ---------------------------------------------------------------------------
  reply_t      pending_replies[$];
  int unsigned live_addr[$], live_len[$];   // blocks currently granted
  int unsigned gone_addr[$], gone_len[$];   // blocks freed, for double frees
  int          mismatches = 0;
  int          snd_idle = 20, rcv_idle = 75;
  bit          long_hold_req = 1'b0;
  int unsigned last_grant;

  // receiver: random stall, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rcv_idle);
      end
    end
  end

  // result check, sampled mid-cycle; the transaction completes at the next edge
  always @(negedge clk_i) begin
    result_t got;
    reply_t  exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {status_e'(status_o), granted_address_o, granted_bytes_o,
             used_bytes_o, peak_bytes_o, committed_bytes_o};
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: status %0d addr %h", status_o, granted_address_o);
      end else begin
        exp = pending_replies.pop_front();
        if (got !== exp.r || (exp.typed_chk && got.status !== exp.typed)) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: exp st %0d addr %h gb %0d used %0d peak %0d com %0d | got st %0d addr %h gb %0d used %0d peak %0d com %0d",
                     exp.r.status, exp.r.addr, exp.r.gbytes, exp.r.used, exp.r.peak,
                     exp.r.committed, got.status, got.addr, got.gbytes, got.used,
                     got.peak, got.committed);
        end
      end
    end
  end

  // watchdog: cycles in which no transaction of any channel moves
  always @(negedge clk_i) begin
    static int quiet = 0;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers; every task starts and ends right after a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_item(item_t it, bit typed_chk, status_e typed);
    bit     acc;
    reply_t rp;
    if ($urandom_range(0, 99) < snd_idle) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= it.cmd;
    request_bytes_i <= it.bytes;
    address_i       <= it.addr;
    do begin
      @(negedge clk_i);
      acc = !in_stall_o;
      @(posedge clk_i);
    end while (!acc);
    rp.r = predict_reply(it);
    rp.typed_chk = typed_chk;
    rp.typed = typed;
    pending_replies.insert(pending_replies.size(), rp);
    last_grant = rp.r.addr;
    if (it.cmd == CMD_ALLOC && rp.r.status == ST_OK) begin
      live_addr.insert(live_addr.size(), rp.r.addr);
      live_len.insert(live_len.size(), rp.r.gbytes);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    bit acc;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 25'(val);
    do begin
      @(negedge clk_i);
      acc = cfg_ready_o;
      @(posedge clk_i);
    end while (!acc);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_BASE: reg_base = val & 32'hFFFFFF;
      CFG_INIT: reg_init = val & MASK19;
      default:  reg_ceil = val & 32'h1FFFFFF;
    endcase
    pool_setup();
    @(posedge clk_i);
  endtask

  // new pool setting: only changed registers are written, each write re-inits
  task automatic set_pool(int unsigned b, int unsigned n, int unsigned c);
    drain();
    repeat (4) @(posedge clk_i);
    if (b != reg_base) write_reg(CFG_BASE, b);
    if (n != reg_init) write_reg(CFG_INIT, n);
    if (c != reg_ceil) write_reg(CFG_CEIL, c);
    live_addr.delete();
    live_len.delete();
    gone_addr.delete();
    gone_len.delete();
  endtask

  // mostly allocate/free pairs on live blocks, the rest noise
  task automatic random_item(output item_t it);
    int unsigned r, s, idx;
    r = $urandom_range(0, 99);
    it = '0;
    if (r < 45) begin
      it.cmd = CMD_ALLOC;
      s = $urandom_range(0, 99);
      if (s < 80)      it.bytes = 16'($urandom_range(1, 300));
      else if (s < 95) it.bytes = 16'($urandom_range(1, 2048));
      else             it.bytes = 16'($urandom);
      it.addr = 24'($urandom);
    end else if (r < 85 && live_addr.size() != 0) begin
      idx = $urandom_range(0, live_addr.size() - 1);
      it.cmd = CMD_FREE;
      it.addr = 24'(live_addr[idx]);
      it.bytes = 16'(live_len[idx]);
      gone_addr.insert(gone_addr.size(), live_addr[idx]);
      gone_len.insert(gone_len.size(), live_len[idx]);
      if (gone_addr.size() > 8) begin
        void'(gone_addr.pop_front());
        void'(gone_len.pop_front());
      end
      live_addr.delete(idx);
      live_len.delete(idx);
    end else begin
      it.cmd = CMD_FREE;
      case ($urandom_range(0, 3))
        0: begin
          if (gone_addr.size() != 0) begin
            idx = $urandom_range(0, gone_addr.size() - 1);
            it.addr = 24'(gone_addr[idx]);
            it.bytes = 16'(gone_len[idx]);
          end else begin
            it.addr = 24'($urandom);
            it.bytes = 16'($urandom);
          end
        end
        1: begin
          it.addr = 24'($urandom);
          it.bytes = 16'($urandom);
        end
        2: begin
          it.addr = 24'(reg_base + ($urandom_range(0, reg_init) & ~32'hF));
          it.bytes = 16'($urandom_range(0, 512));
        end
        default: begin
          it.addr = 24'(reg_base + $urandom_range(0, reg_init));
          it.bytes = 16'($urandom_range(1, 64));
        end
      endcase
    end
  endtask

  task automatic random_run(int count);
    item_t it;
    repeat (count) begin
      random_item(it);
      send_item(it, 1'b0, ST_OK);
    end
  endtask

  // directed rows, run against the reset pool (base 64K, 64K committed)
  row_t directed[] = '{
    '{CMD_ALLOC, 0,     0,        -1, 1, ST_ZERO},
    '{CMD_ALLOC, 65535, 0,        -1, 1, ST_TOO_LARGE},
    '{CMD_ALLOC, 32768, 0,        -1, 0, ST_OK},
    '{CMD_ALLOC, 1,     0,        -1, 0, ST_OK},
    '{CMD_ALLOC, 300,   0,        -1, 0, ST_OK},
    '{CMD_ALLOC, 4100,  0,        -1, 0, ST_OK},   // carved to a 256-byte multiple
    '{CMD_ALLOC, 32768, 0,        -1, 0, ST_OK},   // misses, pool grows
    '{CMD_FREE,  0,     'h10100,  -1, 1, ST_ZERO},
    '{CMD_FREE,  16,    'h10008,  -1, 1, ST_MISALIGNED},
    '{CMD_FREE,  16,    'h1000,   -1, 1, ST_BAD_ADDR},
    '{CMD_FREE,  16,    'h20000,  -1, 1, ST_BAD_ADDR},
    '{CMD_FREE,  32,    'h1FFF0,  -1, 1, ST_CROSS64K},
    '{CMD_FREE,  16,    'h60010,  -1, 1, ST_OUTSIDE},
    '{CMD_FREE,  16,    'hFFFFF0, -1, 1, ST_OUTSIDE},
    '{CMD_FREE,  16,    0,         3, 0, ST_OK},
    '{CMD_FREE,  16,    0,         3, 0, ST_OK},   // same block again
    '{CMD_FREE,  4,     'h1F000,  -1, 0, ST_OK},   // power of two below a granule
    '{CMD_FREE,  40,    'h1E000,  -1, 0, ST_OK},   // sub-granule tail dropped
    '{CMD_FREE,  48,    'h1D000,  -1, 0, ST_OK},   // never allocated, split
    '{CMD_FREE,  512,   0,         4, 0, ST_OK},
    '{CMD_FREE,  4352,  0,         5, 0, ST_OK},
    '{CMD_ALLOC, 32768, 0,        -1, 0, ST_OK},
    '{CMD_ALLOC, 32768, 0,        -1, 0, ST_OK}
  };

  initial begin
    int unsigned grants[];
    item_t       it;
    pool_setup();
    grants = new[directed.size()];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (directed[i]) begin
      it.cmd = directed[i].cmd;
      it.bytes = 16'(directed[i].nbytes);
      it.addr = (directed[i].grant_row >= 0) ? 24'(grants[directed[i].grant_row])
                                             : 24'(directed[i].addr);
      send_item(it, directed[i].typed_chk, directed[i].typed);
      grants[i] = last_grant;
    end

    // small pool, no growth
    set_pool('h10000, 4096, 'h11000);
    random_run(350);

    // sender idles more often than the receiver stalls, until both go to zero
    snd_idle = 75;
    rcv_idle = 20;
    set_pool('h2000, 2048, 'h2800);
    random_run(120);
    long_hold_req = 1'b1;          // receiver holds off, input backs up
    random_run(60);
    drain();                       // pause until every result is back
    random_run(170);

    // unconfigured: base below the lowest freeable address
    set_pool(0, 2048, 'h2800);
    random_run(20);

    // largest initial pool
    set_pool('h10000, POOL_MAX_BYTES, 'h50000);
    random_run(8);

    // ceiling far above the pool, growth up to the pool maximum
    set_pool('h10000, 65536, 'h1000000);
    for (int i = 0; i < 8; i++) begin
      it.cmd = CMD_ALLOC;
      it.bytes = 16'(LARGEST_CLASS);
      it.addr = 24'($urandom);
      send_item(it, 1'b0, ST_OK);
    end

    // base at the top of the 24-bit space, then the smallest valid pool
    set_pool('hFFF000, 4096, 'h1000000);
    random_run(30);
    snd_idle = 0;
    rcv_idle = 0;
    set_pool('h10000, 128, 'h10080);
    random_run(30);

    set_pool('h10000, 4096, 'h11000);
    random_run(450);

    drain();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

[size_class_buddy_allocator.f]
rtl/core/sba_pkg.sv
rtl/core/sba_table.sv
rtl/core/sba_engine.sv
rtl/core/size_class_buddy_allocator.sv
dv/tb_top.sv
